>>> design/prtt_pkg.sv
package prtt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int RTT_BITS      = 20;

  localparam int IDX_W    = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W    = 48;
  localparam int HOST_W   = 32;
  localparam int PORT_W   = 16;
  localparam int SAMPLE_W = 20;
  localparam int TMO_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int SAT_W = (SAMPLE_W > RTT_BITS) ? SAMPLE_W : RTT_BITS;
  localparam int CMP_W = (RTT_BITS + 1 > TMO_W) ? RTT_BITS + 1 : TMO_W;

  localparam logic [RTT_BITS-1:0] RTT_MAX = '1;

  // request codes
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TMO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TMO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TMO     = 2'd2;

  localparam logic [TMO_W-1:0] DEFAULT_TMO_RST = 16'd1000;
  localparam logic [TMO_W-1:0] MIN_TMO_RST     = 16'd200;
  localparam logic [TMO_W-1:0] MAX_TMO_RST     = 16'd5000;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [RTT_BITS-1:0] rtt;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    logic                done;
    logic                hit;
    logic [IDX_W-1:0]    idx;
    logic [RTT_BITS-1:0] rtt;
  } scan_res_t;

  typedef struct packed {
    logic [TMO_W-1:0] dflt;
    logic [TMO_W-1:0] min;
    logic [TMO_W-1:0] max;
  } cfg_t;

  function automatic logic [RTT_BITS-1:0] sat_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAT_W-1:0] ext;
    logic [SAT_W-1:0] lim;
    ext = SAT_W'(s);
    lim = SAT_W'(RTT_MAX);
    if (ext > lim) begin
      return RTT_MAX;
    end
    return RTT_BITS'(ext);
  endfunction

endpackage

>>> design/peer_rtt_timeout_table_top.sv
// The linear key scan reads one table entry per cycle through the single memory read port,
// over the N peers held (up to 1024); a new item is accepted only once the previous one
// has left the sequencer, so the scan bounds throughput.
// A new item is taken while the previous result still waits on the output.
// Reset (rst_n low, synchronous): empties the table via its fill count, clears the
// victim pointer and the handshakes, and loads the timeout registers with defaults.
module peer_rtt_timeout_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [prtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prtt_pkg::TMO_W-1:0]       cfg_wdata,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [prtt_pkg::HOST_W-1:0]      in_peer_host,
  input  logic [prtt_pkg::PORT_W-1:0]      in_peer_port,
  input  logic [prtt_pkg::SAMPLE_W-1:0]    in_rtt_sample_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prtt_pkg::TMO_W-1:0]       out_timeout_ms,
  output logic                             out_hit,
  output logic                             out_evicted
);
  import prtt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;

  cfg_t                cfg_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [IDX_W-1:0]    victim_r;
  logic [IDX_W-1:0]    victim_nxt;

  // latched request
  logic                req_r;
  logic [KEY_W-1:0]    key_r;
  logic [RTT_BITS-1:0] smp_r;

  // staged result, waiting for the output register
  logic [TMO_W-1:0]    res_tmo_r;
  logic                res_hit_r;
  logic                res_evt_r;
  logic [TMO_W-1:0]    res_tmo_nxt;
  logic                res_evt_nxt;

  logic                out_valid_r;
  logic [TMO_W-1:0]    out_tmo_r;
  logic                out_hit_r;
  logic                out_evt_r;

  logic                accept;
  logic                out_free;
  wr_req_t             wr;
  scan_res_t           scan;
  logic [RTT_BITS-1:0] rtt_upd;
  logic [TMO_W-1:0]    alu_tmo;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  prtt_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   ({in_peer_host, in_peer_port}),
    .count (count_r),
    .wr    (wr),
    .res   (scan)
  );

  prtt_alu u_alu (
    .rtt_old (scan.rtt),
    .sample  (smp_r),
    .cfg     (cfg_r),
    .rtt_upd (rtt_upd),
    .tmo     (alu_tmo)
  );

  // Sequencer: accept, scan the occupied slots, then update the table
  // and stage the result in one step, and pass it to the output register once that is free.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    victim_nxt  = victim_r;
    res_tmo_nxt = res_tmo_r;
    res_evt_nxt = res_evt_r;
    wr.en       = 1'b0;
    wr.addr     = scan.idx;
    wr.data.key = key_r;
    wr.data.rtt = smp_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt   = S_OUT;
        res_evt_nxt = 1'b0;
        if (req_r == REQ_QUERY) begin
          res_tmo_nxt = scan.hit ? alu_tmo : cfg_r.dflt;
        end else begin
          res_tmo_nxt = '0;
          wr.en       = 1'b1;
          if (scan.hit) begin
            // smooth the stored value in place
            wr.data.rtt = rtt_upd;
          end else if (count_r < CNT_W'(TABLE_ENTRIES)) begin
            // slots fill in order, so the lowest free one is the fill count
            wr.addr   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end else begin
            // full: overwrite at the round-robin pointer and advance it
            wr.addr     = victim_r;
            res_evt_nxt = 1'b1;
            if (victim_r == IDX_W'(TABLE_ENTRIES - 1)) begin
              victim_nxt = '0;
            end else begin
              victim_nxt = victim_r + IDX_W'(1);
            end
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
      cfg_r.dflt  <= DEFAULT_TMO_RST;
      cfg_r.min   <= MIN_TMO_RST;
      cfg_r.max   <= MAX_TMO_RST;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      victim_r <= victim_nxt;
      // hold the result until taken, drop valid once it leaves
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEFAULT_TMO: cfg_r.dflt <= cfg_wdata;
          REG_MIN_TMO:     cfg_r.min  <= cfg_wdata;
          REG_MAX_TMO:     cfg_r.max  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      key_r <= {in_peer_host, in_peer_port};
      smp_r <= sat_sample(in_rtt_sample_ms);
    end
    if (state_r == S_CALC) begin
      res_hit_r <= scan.hit;
    end
    res_tmo_r <= res_tmo_nxt;
    res_evt_r <= res_evt_nxt;
    if (state_r == S_OUT && out_free) begin
      out_tmo_r <= res_tmo_r;
      out_hit_r <= res_hit_r;
      out_evt_r <= res_evt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_timeout_ms = out_tmo_r;
  assign out_hit        = out_hit_r;
  assign out_evicted    = out_evt_r;

endmodule

>>> design/prtt_scan.sv
module prtt_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [prtt_pkg::KEY_W-1:0]   key,
  input  logic [prtt_pkg::CNT_W-1:0]   count,
  input  prtt_pkg::wr_req_t            wr,
  output prtt_pkg::scan_res_t          res
);
  import prtt_pkg::*;

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rdata_r;
  logic             busy_r;
  logic             pend_r;
  logic [CNT_W-1:0] issue_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [KEY_W-1:0] key_r;
  logic             done_r;
  logic             hit_r;
  logic [IDX_W-1:0] idx_r;

  logic match;
  logic rd_en;
  logic finish;

  // compare the entry read last cycle while the next one is fetched
  assign match  = pend_r && (rdata_r.key == key_r);
  assign rd_en  = busy_r && !match && (issue_r < count);
  assign finish = busy_r && (match || (!pend_r && !rd_en));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= finish;
      pend_r <= rd_en;
      if (start) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      key_r   <= key;
      issue_r <= '0;
    end else if (rd_en) begin
      issue_r <= issue_r + CNT_W'(1);
    end
    pend_idx_r <= issue_r[IDX_W-1:0];
    if (finish) begin
      hit_r <= match;
      idx_r <= pend_idx_r;
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.idx  = idx_r;
  assign res.rtt  = rdata_r.rtt;

endmodule

>>> design/prtt_alu.sv
module prtt_alu (
  input  logic [prtt_pkg::RTT_BITS-1:0] rtt_old,
  input  logic [prtt_pkg::RTT_BITS-1:0] sample,
  input  prtt_pkg::cfg_t                cfg,
  output logic [prtt_pkg::RTT_BITS-1:0] rtt_upd,
  output logic [prtt_pkg::TMO_W-1:0]    tmo
);
  import prtt_pkg::*;

  logic [RTT_BITS+2:0] acc;
  logic [RTT_BITS:0]   avg;
  logic [CMP_W-1:0]    dbl;
  logic [CMP_W-1:0]    lo;
  logic [CMP_W-1:0]    hi;
  logic [CMP_W-1:0]    clamped;

  // (3*old + sample + 2) / 4, rounded to nearest
  always_comb begin
    acc = (RTT_BITS+3)'({rtt_old, 1'b0}) + (RTT_BITS+3)'(rtt_old) + (RTT_BITS+3)'(sample)
          + (RTT_BITS+3)'(2);
    avg = acc[RTT_BITS+2:2];
    if (avg > (RTT_BITS+1)'(RTT_MAX)) begin
      rtt_upd = RTT_MAX;
    end else begin
      rtt_upd = avg[RTT_BITS-1:0];
    end
  end

  // twice the stored (old) RTT, raised to min then capped at max
  always_comb begin
    dbl     = CMP_W'({rtt_old, 1'b0});
    lo      = CMP_W'(cfg.min);
    hi      = CMP_W'(cfg.max);
    clamped = dbl;
    if (clamped < lo) begin
      clamped = lo;
    end
    if (clamped > hi) begin
      clamped = hi;
    end
    tmo = clamped[TMO_W-1:0];
  end

endmodule
